FILE: sv/same_padded_conv2d_forward_unit_defines.svh
// Assertion macros used by the RTL of the convolution unit.
`ifndef SAME_PADDED_CONV2D_FORWARD_UNIT_DEFINES_SVH
`define SAME_PADDED_CONV2D_FORWARD_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define SCV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("scv assertion failed");

`define SCV_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("scv assertion failed");

`else

`define SCV_ASSERT(lbl, prop)

`define SCV_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

FILE: sv/scv_pkg.sv
`default_nettype none
package scv_pkg;

  localparam int MAX_WIDTH    = 64;
  localparam int MAX_HEIGHT   = 64;
  localparam int MAX_KERNEL   = 7;
  localparam int MAX_CHANNELS = 16;

  localparam int KK     = MAX_KERNEL * MAX_KERNEL;
  localparam int WDEPTH = MAX_CHANNELS * KK;
  localparam int LDEPTH = MAX_KERNEL * MAX_WIDTH;
  localparam int PDEPTH = MAX_HEIGHT * MAX_WIDTH;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int CH_W    = $clog2(MAX_CHANNELS);
  localparam int KS_W    = $clog2(MAX_KERNEL);
  localparam int RING_W  = $clog2(MAX_KERNEL);
  localparam int GW_W    = $clog2(MAX_WIDTH + 1);
  localparam int GH_W    = $clog2(MAX_HEIGHT + 1);
  localparam int KW_W    = $clog2(MAX_KERNEL + 1);
  localparam int NC_W    = $clog2(MAX_CHANNELS + 1);
  localparam int WADDR_W = $clog2(WDEPTH);
  localparam int LADDR_W = $clog2(LDEPTH);
  localparam int PADDR_W = $clog2(PDEPTH);
  localparam int YW      = ROW_W + 2;
  localparam int XW      = COL_W + 2;

  localparam int FW_W   = 7;
  localparam int FH_W   = 7;
  localparam int KSZ_W  = 3;
  localparam int CNT_W  = 5;
  localparam int BIAS_W = 48;
  localparam int IDX_W  = 10;
  localparam int PIX_W  = 16;
  localparam int WT_W   = 16;
  localparam int PROD_W = PIX_W + WT_W;
  localparam int ACC_W  = 48;
  localparam int APB_AW = 6;
  localparam int APB_DW = 64;

  localparam logic [ACC_W-1:0] OUT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] OUT_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_KERNEL_SIZE   = 3'd2,
    REG_CHANNEL_COUNT = 3'd3,
    REG_BIAS_VALUE    = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TAP,
    S_DRAIN,
    S_SUM
  } state_t;

  typedef struct packed {
    logic [GW_W-1:0]          w;
    logic [GH_W-1:0]          h;
    logic [KW_W-1:0]          k;
    logic [KW_W-1:0]          s;
    logic [NC_W-1:0]          nc;
    logic signed [BIAS_W-1:0] bias;
    logic                     restart;
  } geom_t;

endpackage
`default_nettype wire

FILE: sv/scv_ram.sv
`default_nettype none
module scv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: sv/scv_cfg.sv
`default_nettype none
module scv_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [scv_pkg::APB_AW-1:0]    paddr,
  input  wire logic [scv_pkg::APB_DW-1:0]    pwdata,
  output logic      [scv_pkg::APB_DW-1:0]    prdata,
  output logic                               pready,
  output scv_pkg::geom_t                     geom
);

  logic [scv_pkg::FW_W-1:0]   fw_r;
  logic [scv_pkg::FH_W-1:0]   fh_r;
  logic [scv_pkg::KSZ_W-1:0]  ks_r;
  logic [scv_pkg::CNT_W-1:0]  nc_r;
  logic [scv_pkg::BIAS_W-1:0] bias_r;
  logic                       wr;
  scv_pkg::cfg_idx_t          idx;
  logic [scv_pkg::KSZ_W-1:0]  kodd;

  assign wr     = psel & penable & pwrite;
  assign idx    = scv_pkg::cfg_idx_t'(paddr[scv_pkg::APB_AW-1:3]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r   <= scv_pkg::FW_W'(8);
      fh_r   <= scv_pkg::FH_W'(8);
      ks_r   <= scv_pkg::KSZ_W'(3);
      nc_r   <= scv_pkg::CNT_W'(1);
      bias_r <= '0;
    end else begin
      if (wr) begin
        case (idx)
          scv_pkg::REG_FRAME_WIDTH: begin
            fw_r <= pwdata[scv_pkg::FW_W-1:0];
          end
          scv_pkg::REG_FRAME_HEIGHT: begin
            fh_r <= pwdata[scv_pkg::FH_W-1:0];
          end
          scv_pkg::REG_KERNEL_SIZE: begin
            ks_r <= pwdata[scv_pkg::KSZ_W-1:0];
          end
          scv_pkg::REG_CHANNEL_COUNT: begin
            nc_r <= pwdata[scv_pkg::CNT_W-1:0];
          end
          scv_pkg::REG_BIAS_VALUE: begin
            bias_r <= pwdata[scv_pkg::BIAS_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      scv_pkg::REG_FRAME_WIDTH:   prdata = scv_pkg::APB_DW'(fw_r);
      scv_pkg::REG_FRAME_HEIGHT:  prdata = scv_pkg::APB_DW'(fh_r);
      scv_pkg::REG_KERNEL_SIZE:   prdata = scv_pkg::APB_DW'(ks_r);
      scv_pkg::REG_CHANNEL_COUNT: prdata = scv_pkg::APB_DW'(nc_r);
      scv_pkg::REG_BIAS_VALUE:    prdata = scv_pkg::APB_DW'(bias_r);
      default:                    prdata = '0;
    endcase
  end

  assign kodd = ks_r | scv_pkg::KSZ_W'(1);

  always_comb begin
    if (fw_r == '0) begin
      geom.w = scv_pkg::GW_W'(1);
    end else if (scv_pkg::GW_W'(fw_r) > scv_pkg::GW_W'(scv_pkg::MAX_WIDTH)) begin
      geom.w = scv_pkg::GW_W'(scv_pkg::MAX_WIDTH);
    end else begin
      geom.w = scv_pkg::GW_W'(fw_r);
    end
    if (fh_r == '0) begin
      geom.h = scv_pkg::GH_W'(1);
    end else if (scv_pkg::GH_W'(fh_r) > scv_pkg::GH_W'(scv_pkg::MAX_HEIGHT)) begin
      geom.h = scv_pkg::GH_W'(scv_pkg::MAX_HEIGHT);
    end else begin
      geom.h = scv_pkg::GH_W'(fh_r);
    end
    if (nc_r == '0) begin
      geom.nc = scv_pkg::NC_W'(1);
    end else if (scv_pkg::NC_W'(nc_r) > scv_pkg::NC_W'(scv_pkg::MAX_CHANNELS)) begin
      geom.nc = scv_pkg::NC_W'(scv_pkg::MAX_CHANNELS);
    end else begin
      geom.nc = scv_pkg::NC_W'(nc_r);
    end
    if (scv_pkg::KW_W'(kodd) > scv_pkg::KW_W'(scv_pkg::MAX_KERNEL)) begin
      geom.k = scv_pkg::KW_W'(scv_pkg::MAX_KERNEL);
    end else begin
      geom.k = scv_pkg::KW_W'(kodd);
    end
    geom.s       = geom.k >> 1;
    geom.bias    = $signed(bias_r);
    geom.restart = wr && (idx inside {scv_pkg::REG_FRAME_WIDTH, scv_pkg::REG_FRAME_HEIGHT,
                                      scv_pkg::REG_KERNEL_SIZE, scv_pkg::REG_CHANNEL_COUNT});
  end

endmodule
`default_nettype wire

FILE: sv/scv_mac.sv
`default_nettype none
module scv_mac (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             clr,
  input  wire logic                             tap_vld,
  input  wire logic signed [scv_pkg::PIX_W-1:0] pix,
  input  wire logic signed [scv_pkg::WT_W-1:0]  wt,
  output logic signed      [scv_pkg::ACC_W-1:0] acc
);

  logic signed [scv_pkg::PROD_W-1:0] prod_r;
  logic                              vld_r;
  logic signed [scv_pkg::ACC_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    prod_r <= pix * wt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      acc_r <= '0;
    end else begin
      vld_r <= tap_vld;
      if (clr) begin
        acc_r <= '0;
      end else if (vld_r) begin
        acc_r <= acc_r + scv_pkg::ACC_W'(prod_r);
      end
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

FILE: sv/same_padded_conv2d_forward_unit.sv
// Same-padded multichannel 2-D convolution, one output map per run.
// Input channel (in_valid/in_ready): in_op 0 loads one kernel weight at
// in_weight_index, in_op 1 takes one pixel; pixels come in raster order,
// one whole channel after another. Geometry and bias sit behind the APB port.
// Result channel (out_valid/out_ready): one transfer per output position,
// emitted on the last channel once its last window pixel has arrived.
// For each output position that a pixel completes, the window taps go one
// per cycle through a single multiplier, fed by the line and weight memory
// read ports, followed by a partial-sum read and, except on the last
// channel, write-back. Interior pixels complete at most one position;
// edge pixels complete up to (K/2+1)^2 positions.
// in_ready is high only while no pixel is being worked on.
// One result register decouples the receiver: a stalled receiver holds the
// next result in place and the block stops until the register is taken.
// Reset clears counters and configuration (8x8 frame, K=3, one channel,
// zero bias); stores are undefined until written. A geometry write restarts
// the map position.
`default_nettype none
`include "same_padded_conv2d_forward_unit_defines.svh"
module same_padded_conv2d_forward_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_op,
  input  wire logic [scv_pkg::IDX_W-1:0]           in_weight_index,
  input  wire logic signed [scv_pkg::WT_W-1:0]     in_weight_value,
  input  wire logic signed [scv_pkg::PIX_W-1:0]    in_pixel_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [scv_pkg::ROW_W-1:0]                out_row,
  output logic [scv_pkg::COL_W-1:0]                out_col,
  output logic signed [scv_pkg::ACC_W-1:0]         out_value,
  output logic                                     out_last_of_run,
  output logic                                     out_frame_done,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [scv_pkg::APB_AW-1:0]          paddr,
  input  wire logic [scv_pkg::APB_DW-1:0]          pwdata,
  output logic [scv_pkg::APB_DW-1:0]               prdata,
  output logic                                     pready
);

  scv_pkg::geom_t g;

  scv_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom    (g)
  );

  scv_pkg::state_t state_r, state_nxt;

  logic [scv_pkg::ROW_W-1:0]  pr_r;
  logic [scv_pkg::COL_W-1:0]  pc_r;
  logic [scv_pkg::CH_W-1:0]   ch_r;
  logic [scv_pkg::RING_W-1:0] ring_r;

  logic [scv_pkg::ROW_W-1:0]  pr_s_r;
  logic [scv_pkg::RING_W-1:0] ring_s_r;
  logic [scv_pkg::CH_W-1:0]   ch_s_r;
  logic                       lastch_s_r;
  logic [scv_pkg::ROW_W-1:0]  r1_r;
  logic [scv_pkg::COL_W-1:0]  c0_r, c1_r;
  logic [scv_pkg::ROW_W-1:0]  pos_r_r;
  logic [scv_pkg::COL_W-1:0]  pos_c_r;
  logic [scv_pkg::KS_W-1:0]   i_r, j_r;
  logic                       drain_r;
  logic                       v1_r;

  logic                       out_valid_r;
  logic [scv_pkg::ROW_W-1:0]  out_row_r;
  logic [scv_pkg::COL_W-1:0]  out_col_r;
  logic [scv_pkg::ACC_W-1:0]  out_value_r;
  logic                       out_last_r;
  logic                       out_done_r;

  logic                       accept, pix_acc, wt_acc;
  logic [scv_pkg::ROW_W-1:0]  pr_n;
  logic [scv_pkg::COL_W-1:0]  pc_n;
  logic [scv_pkg::CH_W-1:0]   ch_n;
  logic [scv_pkg::RING_W-1:0] ring_n;
  logic                       lastch_n, last_row, last_col, pr_ge_s, pc_ge_s;
  logic [scv_pkg::ROW_W-1:0]  r0_n, r1_n;
  logic [scv_pkg::COL_W-1:0]  c0_n, c1_n;
  logic                       nonempty;

  logic [scv_pkg::YW-1:0]       y_u, d_u;
  logic [scv_pkg::XW-1:0]       x_u;
  logic                         y_in, x_in, tap_vld, last_tap;
  logic [scv_pkg::RING_W:0]     rdiff;
  logic [scv_pkg::RING_W-1:0]   ring_t;
  logic [scv_pkg::LADDR_W-1:0]  l_raddr, l_waddr;
  logic [scv_pkg::WADDR_W-1:0]  w_raddr;
  logic [scv_pkg::PADDR_W-1:0]  p_addr;
  logic                         w_we;
  logic signed [scv_pkg::PIX_W-1:0] pix_q;
  logic signed [scv_pkg::WT_W-1:0]  wt_q;
  logic [scv_pkg::ACC_W-1:0]    psum_q;
  logic signed [scv_pkg::ACC_W-1:0] acc;

  logic                         done_pos, out_free, go, clr_acc, psum_we, out_load;
  logic signed [scv_pkg::ACC_W:0]   total;
  logic signed [scv_pkg::ACC_W+1:0] fsum;
  logic [scv_pkg::ACC_W-1:0]        sat_val;
  logic                             frame_last;

  assign in_ready = (state_r == scv_pkg::S_IDLE);
  assign accept   = in_valid & in_ready;
  assign pix_acc  = accept & in_op;
  assign wt_acc   = accept & ~in_op;

  always_comb begin
    pr_n     = (scv_pkg::GH_W'(pr_r) >= g.h) ? '0 : pr_r;
    ring_n   = (scv_pkg::GH_W'(pr_r) >= g.h) ? '0 : ring_r;
    pc_n     = (scv_pkg::GW_W'(pc_r) >= g.w) ? '0 : pc_r;
    ch_n     = (scv_pkg::NC_W'(ch_r) >= g.nc) ? '0 : ch_r;
    lastch_n = (scv_pkg::NC_W'(ch_n) + scv_pkg::NC_W'(1)) == g.nc;
    last_row = (scv_pkg::GH_W'(pr_n) + scv_pkg::GH_W'(1)) == g.h;
    last_col = (scv_pkg::GW_W'(pc_n) + scv_pkg::GW_W'(1)) == g.w;
    pr_ge_s  = scv_pkg::YW'(pr_n) >= scv_pkg::YW'(g.s);
    pc_ge_s  = scv_pkg::XW'(pc_n) >= scv_pkg::XW'(g.s);
    r0_n     = pr_ge_s ? pr_n - scv_pkg::ROW_W'(g.s) : '0;
    r1_n     = last_row ? pr_n : r0_n;
    c0_n     = pc_ge_s ? pc_n - scv_pkg::COL_W'(g.s) : '0;
    c1_n     = last_col ? pc_n : c0_n;
    nonempty = (last_row | pr_ge_s) & (last_col | pc_ge_s);
  end

  always_comb begin
    y_u      = scv_pkg::YW'(pos_r_r) + scv_pkg::YW'(i_r) - scv_pkg::YW'(g.s);
    x_u      = scv_pkg::XW'(pos_c_r) + scv_pkg::XW'(j_r) - scv_pkg::XW'(g.s);
    y_in     = !y_u[scv_pkg::YW-1] && (y_u < scv_pkg::YW'(g.h));
    x_in     = !x_u[scv_pkg::XW-1] && (x_u < scv_pkg::XW'(g.w));
    d_u      = scv_pkg::YW'(pr_s_r) - y_u;
    rdiff    = {1'b0, ring_s_r} - {1'b0, d_u[scv_pkg::RING_W-1:0]};
    ring_t   = rdiff[scv_pkg::RING_W] ?
               rdiff[scv_pkg::RING_W-1:0] + scv_pkg::RING_W'(scv_pkg::MAX_KERNEL) :
               rdiff[scv_pkg::RING_W-1:0];
    l_raddr  = scv_pkg::LADDR_W'(ring_t) * scv_pkg::LADDR_W'(scv_pkg::MAX_WIDTH)
             + scv_pkg::LADDR_W'(x_u[scv_pkg::COL_W-1:0]);
    w_raddr  = scv_pkg::WADDR_W'(ch_s_r) * scv_pkg::WADDR_W'(scv_pkg::KK)
             + scv_pkg::WADDR_W'(i_r) * scv_pkg::WADDR_W'(scv_pkg::MAX_KERNEL)
             + scv_pkg::WADDR_W'(j_r);
    last_tap = (i_r == scv_pkg::KS_W'(g.k - scv_pkg::KW_W'(1))) &&
               (j_r == scv_pkg::KS_W'(g.k - scv_pkg::KW_W'(1)));
    l_waddr  = scv_pkg::LADDR_W'(ring_n) * scv_pkg::LADDR_W'(scv_pkg::MAX_WIDTH)
             + scv_pkg::LADDR_W'(pc_n);
    p_addr   = scv_pkg::PADDR_W'(pos_r_r) * scv_pkg::PADDR_W'(scv_pkg::MAX_WIDTH)
             + scv_pkg::PADDR_W'(pos_c_r);
    w_we     = wt_acc &&
               ((scv_pkg::IDX_W + 1)'(in_weight_index) < (scv_pkg::IDX_W + 1)'(scv_pkg::WDEPTH));
  end

  scv_ram #(.WIDTH(scv_pkg::WT_W), .DEPTH(scv_pkg::WDEPTH)) u_wt_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (scv_pkg::WADDR_W'(in_weight_index)),
    .wdata (in_weight_value),
    .raddr (w_raddr),
    .rdata (wt_q)
  );

  scv_ram #(.WIDTH(scv_pkg::PIX_W), .DEPTH(scv_pkg::LDEPTH)) u_line_ram (
    .clk   (clk),
    .we    (pix_acc),
    .waddr (l_waddr),
    .wdata (in_pixel_value),
    .raddr (l_raddr),
    .rdata (pix_q)
  );

  scv_ram #(.WIDTH(scv_pkg::ACC_W), .DEPTH(scv_pkg::PDEPTH)) u_psum_ram (
    .clk   (clk),
    .we    (psum_we),
    .waddr (p_addr),
    .wdata (total[scv_pkg::ACC_W-1:0]),
    .raddr (p_addr),
    .rdata (psum_q)
  );

  scv_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (clr_acc),
    .tap_vld (v1_r),
    .pix     (pix_q),
    .wt      (wt_q),
    .acc     (acc)
  );

  always_comb begin
    done_pos   = (pos_r_r == r1_r) && (pos_c_r == c1_r);
    out_free   = !out_valid_r || out_ready;
    go         = !lastch_s_r || out_free;
    total      = scv_pkg::ACC_W'(0) + $signed({acc[scv_pkg::ACC_W-1], acc})
               + ((ch_s_r != '0) ?
                  $signed({psum_q[scv_pkg::ACC_W-1], psum_q}) : $signed((scv_pkg::ACC_W + 1)'(0)));
    fsum       = $signed({total[scv_pkg::ACC_W], total})
               + $signed({{2{g.bias[scv_pkg::BIAS_W-1]}}, g.bias});
    if (!fsum[scv_pkg::ACC_W+1] && (fsum[scv_pkg::ACC_W:scv_pkg::ACC_W-1] != 2'b00)) begin
      sat_val = scv_pkg::OUT_MAX;
    end else if (fsum[scv_pkg::ACC_W+1] &&
                 (fsum[scv_pkg::ACC_W:scv_pkg::ACC_W-1] != 2'b11)) begin
      sat_val = scv_pkg::OUT_MIN;
    end else begin
      sat_val = fsum[scv_pkg::ACC_W-1:0];
    end
    frame_last = ((scv_pkg::GH_W'(pos_r_r) + scv_pkg::GH_W'(1)) == g.h) &&
                 ((scv_pkg::GW_W'(pos_c_r) + scv_pkg::GW_W'(1)) == g.w);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      scv_pkg::S_IDLE: begin
        if (pix_acc && nonempty) begin
          state_nxt = scv_pkg::S_TAP;
        end
      end
      scv_pkg::S_TAP: begin
        if (last_tap) begin
          state_nxt = scv_pkg::S_DRAIN;
        end
      end
      scv_pkg::S_DRAIN: begin
        if (drain_r) begin
          state_nxt = scv_pkg::S_SUM;
        end
      end
      scv_pkg::S_SUM: begin
        if (go) begin
          state_nxt = done_pos ? scv_pkg::S_IDLE : scv_pkg::S_TAP;
        end
      end
      default: state_nxt = scv_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    tap_vld  = 1'b0;
    clr_acc  = 1'b0;
    psum_we  = 1'b0;
    out_load = 1'b0;
    case (state_r)
      scv_pkg::S_IDLE:  clr_acc = 1'b1;
      scv_pkg::S_TAP:   tap_vld = y_in & x_in;
      scv_pkg::S_DRAIN: clr_acc = 1'b0;
      scv_pkg::S_SUM: begin
        clr_acc  = go;
        psum_we  = !lastch_s_r;
        out_load = lastch_s_r & out_free;
      end
      default: clr_acc = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scv_pkg::S_IDLE;
      pr_r    <= '0;
      pc_r    <= '0;
      ch_r    <= '0;
      ring_r  <= '0;
      drain_r <= 1'b0;
      v1_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      drain_r <= (state_r == scv_pkg::S_DRAIN) ? ~drain_r : 1'b0;
      v1_r    <= tap_vld;
      if (g.restart) begin
        pr_r   <= '0;
        pc_r   <= '0;
        ch_r   <= '0;
        ring_r <= '0;
      end else if (pix_acc) begin
        if (last_col) begin
          pc_r <= '0;
          if (last_row) begin
            pr_r   <= '0;
            ring_r <= '0;
            ch_r   <= lastch_n ? '0 : ch_n + scv_pkg::CH_W'(1);
          end else begin
            pr_r   <= pr_n + scv_pkg::ROW_W'(1);
            ring_r <= (ring_n == scv_pkg::RING_W'(scv_pkg::MAX_KERNEL - 1)) ?
                      '0 : ring_n + scv_pkg::RING_W'(1);
            ch_r   <= ch_n;
          end
        end else begin
          pc_r   <= pc_n + scv_pkg::COL_W'(1);
          pr_r   <= pr_n;
          ring_r <= ring_n;
          ch_r   <= ch_n;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      pr_s_r     <= pr_n;
      ring_s_r   <= ring_n;
      ch_s_r     <= ch_n;
      lastch_s_r <= lastch_n;
      r1_r       <= r1_n;
      c0_r       <= c0_n;
      c1_r       <= c1_n;
      pos_r_r    <= r0_n;
      pos_c_r    <= c0_n;
      i_r        <= '0;
      j_r        <= '0;
    end else if (state_r == scv_pkg::S_TAP) begin
      if (j_r == scv_pkg::KS_W'(g.k - scv_pkg::KW_W'(1))) begin
        j_r <= '0;
        i_r <= i_r + scv_pkg::KS_W'(1);
      end else begin
        j_r <= j_r + scv_pkg::KS_W'(1);
      end
    end else if (state_r == scv_pkg::S_SUM && go && !done_pos) begin
      i_r <= '0;
      j_r <= '0;
      if (pos_c_r == c1_r) begin
        pos_c_r <= c0_r;
        pos_r_r <= pos_r_r + scv_pkg::ROW_W'(1);
      end else begin
        pos_c_r <= pos_c_r + scv_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r   <= pos_r_r;
      out_col_r   <= pos_c_r;
      out_value_r <= sat_val;
      out_last_r  <= done_pos;
      out_done_r  <= frame_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row         = out_row_r;
  assign out_col         = out_col_r;
  assign out_value       = $signed(out_value_r);
  assign out_last_of_run = out_last_r;
  assign out_frame_done  = out_done_r;

  `SCV_ASSERT(a_ring_range, ring_r < scv_pkg::RING_W'(scv_pkg::MAX_KERNEL))
  `SCV_ASSERT(a_tap_addr, tap_vld |-> (l_raddr < scv_pkg::LADDR_W'(scv_pkg::LDEPTH)))
  `SCV_ASSERT_NEXT(a_sum_stall, state_r == scv_pkg::S_SUM && lastch_s_r && out_valid_r && !out_ready, state_r == scv_pkg::S_SUM)
  `SCV_ASSERT_NEXT(a_drain_empty, state_r == scv_pkg::S_DRAIN && drain_r, !v1_r)

endmodule
`default_nettype wire
